[hdl/srs_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants of the sensor readout sequencer.
// Used by srs_calc and sensor_readout_sequencer; depends on nothing.
package srs_pkg;

  localparam int unsigned CAL_COUNT = 11;
  localparam int unsigned CAL_IDX_W = $clog2(CAL_COUNT);

  localparam logic [2:0] CMD_START = 3'd0;
  localparam logic [2:0] CMD_WRITE = 3'd1;
  localparam logic [2:0] CMD_READ  = 3'd2;
  localparam logic [2:0] CMD_STOP  = 3'd3;
  localparam logic [2:0] CMD_WAIT  = 3'd4;
  localparam logic [2:0] CMD_DONE  = 3'd5;

  localparam logic [4:0] POS_IDLE     = 5'd0;
  localparam logic [4:0] POS_ID       = 5'd1;
  localparam logic [4:0] POS_CAL0     = 5'd2;
  localparam logic [4:0] POS_UT_MEAS  = 5'(2 + 2 * CAL_COUNT);
  localparam logic [4:0] POS_UT_MSB   = 5'(3 + 2 * CAL_COUNT);
  localparam logic [4:0] POS_UT_LSB   = 5'(4 + 2 * CAL_COUNT);
  localparam logic [4:0] POS_UP_MEAS  = 5'(5 + 2 * CAL_COUNT);
  localparam logic [4:0] POS_UP_MSB   = 5'(6 + 2 * CAL_COUNT);
  localparam logic [4:0] POS_UP_LSB   = 5'(7 + 2 * CAL_COUNT);
  localparam logic [4:0] POS_STOPPING = 5'(8 + 2 * CAL_COUNT);

  localparam logic [7:0] DEV_ADDR_WR   = 8'hEE;
  localparam logic [7:0] DEV_ADDR_RD   = 8'hEF;
  localparam logic [7:0] REG_ID        = 8'hD0;
  localparam logic [7:0] REG_CTRL      = 8'hF4;
  localparam logic [7:0] CONV_TEMP     = 8'h2E;
  localparam logic [7:0] CONV_PRESS    = 8'h34;
  localparam logic [7:0] REG_DATA_MSB  = 8'hF6;
  localparam logic [7:0] REG_DATA_LSB  = 8'hF7;
  localparam logic [7:0] REG_CAL0      = 8'hAA;

  localparam logic [7:0] WAIT_RESET    = 8'd5;
  localparam logic [1:0] CFG_ADDR_WAIT = 2'd0;

  localparam logic [33:0] ROUND_BIAS   = 34'd8;

  typedef struct packed {
    logic [2:0] cmd;
    logic [7:0] arg;
  } issue_t;

  typedef struct packed {
    logic [15:0] ut;
    logic [15:0] ac5;
    logic [15:0] ac6;
    logic [15:0] mc;
    logic [15:0] md;
  } calc_in_t;

endpackage

[hdl/srs_calc.sv]
`timescale 1ns / 1ps
// Iterative temperature compensation unit built around one shared 34-bit adder.
// Runs a serial multiply and a restoring divide; depends on srs_pkg.
module srs_calc (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  srs_pkg::calc_in_t operands,
  output logic              done,
  output logic [15:0]       temperature
);

  localparam logic [3:0] C_IDLE  = 4'd0;
  localparam logic [3:0] C_SUB   = 4'd1;
  localparam logic [3:0] C_MUL   = 4'd2;
  localparam logic [3:0] C_DEN   = 4'd3;
  localparam logic [3:0] C_ABS_N = 4'd4;
  localparam logic [3:0] C_ABS_D = 4'd5;
  localparam logic [3:0] C_DIV   = 4'd6;
  localparam logic [3:0] C_SIGN  = 4'd7;
  localparam logic [3:0] C_B5    = 4'd8;
  localparam logic [3:0] C_RND   = 4'd9;

  logic [3:0]  st_r, st_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        done_r;

  logic [15:0] ut_r, ac5_r, ac6_r, mc_r, md_r;
  logic [16:0] a_r;
  logic [33:0] acc_r;
  logic [17:0] x1_r;
  logic [18:0] den_r;
  logic [18:0] dmag_r;
  logic [18:0] rem_r;
  logic [26:0] q_r;
  logic [27:0] x2_r;
  logic [15:0] temp_r;

  logic [33:0] op_a, op_b, sum;
  logic        sub;
  logic        q_neg;
  logic [15:0] sat;

  assign q_neg = mc_r[15] ^ den_r[18];

  always_comb begin
    op_a = '0;
    op_b = '0;
    sub  = 1'b0;
    unique case (st_r)
      C_SUB: begin
        op_a = {18'b0, ut_r};
        op_b = {18'b0, ac6_r};
        sub  = 1'b1;
      end
      C_MUL: begin
        op_a = {acc_r[32:0], 1'b0};
        op_b = ac5_r[cnt_r[3:0]] ? {{17{a_r[16]}}, a_r} : '0;
      end
      C_DEN: begin
        op_a = {{15{acc_r[33]}}, acc_r[33:15]};
        op_b = {{18{md_r[15]}}, md_r};
      end
      C_ABS_N: begin
        op_b = {{7{mc_r[15]}}, mc_r, 11'b0};
        sub  = mc_r[15];
      end
      C_ABS_D: begin
        op_b = {{15{den_r[18]}}, den_r};
        sub  = den_r[18];
      end
      C_DIV: begin
        op_a = {14'b0, rem_r, q_r[26]};
        op_b = {15'b0, dmag_r};
        sub  = 1'b1;
      end
      C_SIGN: begin
        op_b = {7'b0, q_r};
        sub  = q_neg;
      end
      C_B5: begin
        op_a = {{16{x1_r[17]}}, x1_r};
        op_b = {{6{x2_r[27]}}, x2_r};
      end
      C_RND: begin
        op_a = acc_r;
        op_b = srs_pkg::ROUND_BIAS;
      end
      default: begin
        op_a = '0;
      end
    endcase
  end

  assign sum = op_a + (sub ? ~op_b : op_b) + {33'b0, sub};

  always_comb begin
    if (sum[33:19] == {15{sum[33]}}) begin
      sat = sum[19:4];
    end else begin
      sat = sum[33] ? 16'h8000 : 16'h7FFF;
    end
  end

  always_comb begin
    st_nxt  = st_r;
    cnt_nxt = cnt_r;
    unique case (st_r)
      C_IDLE: begin
        if (start) begin
          st_nxt = C_SUB;
        end
      end
      C_SUB: begin
        st_nxt  = C_MUL;
        cnt_nxt = 5'd15;
      end
      C_MUL: begin
        if (cnt_r == 5'd0) begin
          st_nxt = C_DEN;
        end else begin
          cnt_nxt = cnt_r - 5'd1;
        end
      end
      C_DEN:   st_nxt = C_ABS_N;
      C_ABS_N: st_nxt = C_ABS_D;
      C_ABS_D: begin
        cnt_nxt = 5'd26;
        st_nxt  = (den_r == '0) ? C_B5 : C_DIV;
      end
      C_DIV: begin
        if (cnt_r == 5'd0) begin
          st_nxt = C_SIGN;
        end else begin
          cnt_nxt = cnt_r - 5'd1;
        end
      end
      C_SIGN:  st_nxt = C_B5;
      C_B5:    st_nxt = C_RND;
      C_RND:   st_nxt = C_IDLE;
      default: st_nxt = C_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= C_IDLE;
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      cnt_r  <= cnt_nxt;
      done_r <= (st_r == C_RND);
    end
  end

  always_ff @(posedge clk) begin
    unique case (st_r)
      C_IDLE: begin
        if (start) begin
          ut_r  <= operands.ut;
          ac5_r <= operands.ac5;
          ac6_r <= operands.ac6;
          mc_r  <= operands.mc;
          md_r  <= operands.md;
        end
      end
      C_SUB: begin
        a_r   <= sum[16:0];
        acc_r <= '0;
      end
      C_MUL: acc_r <= sum;
      C_DEN: begin
        x1_r  <= acc_r[32:15];
        den_r <= sum[18:0];
      end
      C_ABS_N: q_r <= sum[26:0];
      C_ABS_D: begin
        dmag_r <= sum[18:0];
        rem_r  <= '0;
        if (den_r == '0) begin
          x2_r <= '0;
        end
      end
      C_DIV: begin
        if (!sum[33]) begin
          rem_r <= sum[18:0];
        end else begin
          rem_r <= {rem_r[17:0], q_r[26]};
        end
        q_r <= {q_r[25:0], ~sum[33]};
      end
      C_SIGN: x2_r   <= sum[27:0];
      C_B5:   acc_r  <= sum;
      C_RND:  temp_r <= sat;
      default: begin
        temp_r <= temp_r;
      end
    endcase
  end

  assign done        = done_r;
  assign temperature = temp_r;

endmodule

[hdl/sensor_readout_sequencer.sv]
`timescale 1ns / 1ps
// Each accepted request, a readout start or a completion of the last bus command, is answered
// with at most one bus command, normally in the cycle after it is taken. The completion that
// delivers the low byte of the raw temperature instead keeps in_tready low while srs_calc runs
// its shared adder through 16 multiply steps and 27 divide steps, skipping the divide when
// the divisor is zero; the next command then carries the compensated temperature. A finished
// result waits in the output register, and the next request is taken in the same cycle that
// the result is taken.
// Top level of the sequencer; depends on srs_pkg and srs_calc.
module sensor_readout_sequencer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // ack [0], read_byte [8:1], zero [15:9]
  input  logic        in_tuser,   // mode [0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // command_arg [7:0], temperature [23:8],
                                  // raw_temperature [39:24], raw_pressure [55:40],
                                  // status [56], zero [63:57]
  output logic [2:0]  out_tuser,  // command [2:0]
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [1:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [4:0]  pos_r, pos_nxt;
  logic [2:0]  step_r, step_nxt;
  logic [15:0] cal_r [srs_pkg::CAL_COUNT];
  logic [15:0] rawt_r, rawt_nxt;
  logic [15:0] rawp_r, rawp_nxt;
  logic [15:0] temp_r, temp_nxt;
  logic        err_r, err_nxt;
  logic [7:0]  wait_r;
  logic        busy_r;

  logic        out_valid_r;
  logic [2:0]  out_cmd_r;
  logic [7:0]  out_arg_r;
  logic [15:0] out_temp_r, out_rawt_r, out_rawp_r;
  logic        out_stat_r;

  logic        in_fire, cfg_wr;
  logic        mode, ack;
  logic [7:0]  rd_byte;
  logic        idle_like, measure, was_write, at_last;
  logic        emit, calc_go, cal_store;
  srs_pkg::issue_t iss;
  logic [4:0]  cal_k;
  logic [srs_pkg::CAL_IDX_W-1:0] cal_w;

  srs_pkg::calc_in_t calc_ops;
  logic        calc_done;
  logic [15:0] calc_temp;

  function automatic srs_pkg::issue_t issue(input logic [4:0] pos, input logic [2:0] step,
                                            input logic [7:0] wait_ms);
    srs_pkg::issue_t r;
    logic [7:0] idx;
    if (pos == srs_pkg::POS_ID) begin
      idx = srs_pkg::REG_ID;
    end else if (pos == srs_pkg::POS_UT_MSB || pos == srs_pkg::POS_UP_MSB) begin
      idx = srs_pkg::REG_DATA_MSB;
    end else if (pos == srs_pkg::POS_UT_LSB || pos == srs_pkg::POS_UP_LSB) begin
      idx = srs_pkg::REG_DATA_LSB;
    end else begin
      idx = srs_pkg::REG_CAL0 + {3'b0, pos} - {3'b0, srs_pkg::POS_CAL0};
    end
    r = '{cmd: srs_pkg::CMD_START, arg: 8'd0};
    if (pos == srs_pkg::POS_UT_MEAS || pos == srs_pkg::POS_UP_MEAS) begin
      unique case (step)
        3'd0: r = '{cmd: srs_pkg::CMD_START, arg: 8'd0};
        3'd1: r = '{cmd: srs_pkg::CMD_WRITE, arg: srs_pkg::DEV_ADDR_WR};
        3'd2: r = '{cmd: srs_pkg::CMD_WRITE, arg: srs_pkg::REG_CTRL};
        3'd3: r = '{cmd: srs_pkg::CMD_WRITE,
                    arg: (pos == srs_pkg::POS_UT_MEAS) ? srs_pkg::CONV_TEMP
                                                       : srs_pkg::CONV_PRESS};
        default: r = '{cmd: srs_pkg::CMD_WAIT, arg: wait_ms};
      endcase
    end else begin
      unique case (step)
        3'd0: r = '{cmd: srs_pkg::CMD_START, arg: 8'd0};
        3'd1: r = '{cmd: srs_pkg::CMD_WRITE, arg: srs_pkg::DEV_ADDR_WR};
        3'd2: r = '{cmd: srs_pkg::CMD_WRITE, arg: idx};
        3'd3: r = '{cmd: srs_pkg::CMD_START, arg: 8'd0};
        3'd4: r = '{cmd: srs_pkg::CMD_WRITE, arg: srs_pkg::DEV_ADDR_RD};
        default: r = '{cmd: srs_pkg::CMD_READ, arg: 8'd0};
      endcase
    end
    return r;
  endfunction

  assign mode    = in_tuser;
  assign ack     = in_tdata[0];
  assign rd_byte = in_tdata[8:1];

  assign in_tready = !busy_r && (!out_valid_r || out_tready);
  assign in_fire   = in_tvalid && in_tready;

  assign idle_like = (pos_r == srs_pkg::POS_IDLE) || (pos_r > srs_pkg::POS_STOPPING);
  assign measure   = (pos_r == srs_pkg::POS_UT_MEAS) || (pos_r == srs_pkg::POS_UP_MEAS);
  assign was_write = measure ? (step_r >= 3'd1 && step_r <= 3'd3)
                             : (step_r == 3'd1 || step_r == 3'd2 || step_r == 3'd4);
  assign at_last   = measure ? (step_r >= 3'd4) : (step_r >= 3'd5);

  assign cal_k = pos_r - srs_pkg::POS_CAL0;
  assign cal_w = cal_k[srs_pkg::CAL_IDX_W:1];

  always_comb begin
    pos_nxt   = pos_r;
    step_nxt  = step_r;
    rawt_nxt  = rawt_r;
    rawp_nxt  = rawp_r;
    temp_nxt  = temp_r;
    err_nxt   = err_r;
    emit      = 1'b0;
    calc_go   = 1'b0;
    cal_store = 1'b0;
    iss       = '{cmd: srs_pkg::CMD_START, arg: 8'd0};
    if (idle_like) begin
      pos_nxt = srs_pkg::POS_IDLE;
      if (!mode) begin
        err_nxt  = 1'b0;
        rawt_nxt = '0;
        rawp_nxt = '0;
        temp_nxt = '0;
        pos_nxt  = srs_pkg::POS_ID;
        step_nxt = 3'd0;
        emit     = 1'b1;
        iss      = issue(srs_pkg::POS_ID, 3'd0, wait_r);
      end
    end else if (mode) begin
      emit = 1'b1;
      if (pos_r == srs_pkg::POS_STOPPING) begin
        pos_nxt  = srs_pkg::POS_IDLE;
        step_nxt = 3'd0;
        iss      = '{cmd: srs_pkg::CMD_DONE, arg: 8'd0};
      end else if (was_write && !ack) begin
        err_nxt  = 1'b1;
        pos_nxt  = srs_pkg::POS_STOPPING;
        step_nxt = 3'd0;
        iss      = '{cmd: srs_pkg::CMD_STOP, arg: 8'd0};
      end else if (!at_last) begin
        step_nxt = step_r + 3'd1;
        iss      = issue(pos_r, step_r + 3'd1, wait_r);
      end else begin
        step_nxt = 3'd0;
        if (pos_r >= srs_pkg::POS_CAL0 && pos_r < srs_pkg::POS_UT_MEAS) begin
          cal_store = 1'b1;
        end
        if (pos_r == srs_pkg::POS_UT_MSB) begin
          rawt_nxt = {rd_byte, 8'h00};
        end
        if (pos_r == srs_pkg::POS_UT_LSB) begin
          rawt_nxt = {rawt_r[15:8], rd_byte};
          calc_go  = 1'b1;
          emit     = 1'b0;
        end
        if (pos_r == srs_pkg::POS_UP_MSB) begin
          rawp_nxt = {rd_byte, 8'h00};
        end
        if (pos_r == srs_pkg::POS_UP_LSB) begin
          rawp_nxt = {rawp_r[15:8], rd_byte};
          pos_nxt  = srs_pkg::POS_STOPPING;
          iss      = '{cmd: srs_pkg::CMD_STOP, arg: 8'd0};
        end else begin
          pos_nxt = pos_r + 5'd1;
          iss     = issue(pos_r + 5'd1, 3'd0, wait_r);
        end
      end
    end
  end

  assign calc_ops = '{ut: rawt_nxt, ac5: cal_r[4], ac6: cal_r[5], mc: cal_r[9], md: cal_r[10]};

  srs_calc u_calc (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (in_fire && calc_go),
    .operands    (calc_ops),
    .done        (calc_done),
    .temperature (calc_temp)
  );

  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= srs_pkg::POS_IDLE;
      step_r      <= 3'd0;
      rawt_r      <= '0;
      rawp_r      <= '0;
      temp_r      <= '0;
      err_r       <= 1'b0;
      wait_r      <= srs_pkg::WAIT_RESET;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr && cfg_paddr == srs_pkg::CFG_ADDR_WAIT) begin
        wait_r <= cfg_pwdata[7:0];
      end
      if (calc_done) begin
        busy_r      <= 1'b0;
        temp_r      <= calc_temp;
        out_valid_r <= 1'b1;
      end else if (in_fire) begin
        pos_r       <= pos_nxt;
        step_r      <= step_nxt;
        rawt_r      <= rawt_nxt;
        rawp_r      <= rawp_nxt;
        temp_r      <= temp_nxt;
        err_r       <= err_nxt;
        busy_r      <= calc_go;
        out_valid_r <= emit;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && cal_store) begin
      if (!cal_k[0]) begin
        cal_r[cal_w][15:8] <= rd_byte;
      end else begin
        cal_r[cal_w][7:0] <= rd_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (calc_done) begin
      out_cmd_r  <= srs_pkg::CMD_START;
      out_arg_r  <= 8'd0;
      out_temp_r <= calc_temp;
      out_rawt_r <= rawt_r;
      out_rawp_r <= rawp_r;
      out_stat_r <= err_r;
    end else if (in_fire && emit) begin
      out_cmd_r  <= iss.cmd;
      out_arg_r  <= iss.arg;
      out_temp_r <= temp_nxt;
      out_rawt_r <= rawt_nxt;
      out_rawp_r <= rawp_nxt;
      out_stat_r <= err_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_cmd_r;
  assign out_tdata  = {7'b0, out_stat_r, out_rawp_r, out_rawt_r, out_temp_r, out_arg_r};

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == srs_pkg::CFG_ADDR_WAIT) ? {24'b0, wait_r} : 32'b0;

  a_busy_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !in_tready)
    else $error("request accepted while the temperature unit is busy");

  a_done_only_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
    calc_done |-> busy_r)
    else $error("temperature unit finished without a pending computation");

  a_done_emits_start: assert property (@(posedge clk) disable iff (!rst_n)
    calc_done |=> out_tvalid && out_tuser == srs_pkg::CMD_START)
    else $error("finished computation did not present the pressure start command");

  a_stopping_step_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (pos_r == srs_pkg::POS_STOPPING) |-> (step_r == 3'd0))
    else $error("bus step not cleared on the way to stop");

endmodule
